FILE: hdl/twlk_pkg.sv
// shared types and constants of the two-level page table walker
package twlk_pkg;

    localparam int CONTEXT_COUNT_DFLT = 16;
    localparam int CTX_W   = 4;
    localparam int FRAME_W = 28;
    localparam int VA_W    = 40;
    localparam int DATA_W  = 64;
    localparam int PAGE_W  = 12;

    // item operation codes
    typedef enum logic [1:0] {
        OP_WRITE_BASE = 2'd0,
        OP_READ_BASE  = 2'd1,
        OP_TRANSLATE  = 2'd2,
        OP_READ_DATA  = 2'd3
    } t_op;

    // result kinds
    typedef enum logic [1:0] {
        KIND_READBACK = 2'd0,
        KIND_MEM_REQ  = 2'd1,
        KIND_XLATE    = 2'd2
    } t_kind;

    // walk state
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DIR   = 2'd1,
        PH_TABLE = 2'd2
    } t_phase;

    typedef struct packed {
        t_op                 operation;
        logic [CTX_W-1:0]    context_id;
        logic [FRAME_W-1:0]  base_frame;
        logic [VA_W-1:0]     virtual_address;
        logic [DATA_W-1:0]   read_data;
    } t_in_item;

    typedef struct packed {
        t_kind               result_kind;
        logic [FRAME_W-1:0]  readback_frame;
        logic [VA_W-1:0]     memory_address;
        logic [VA_W-1:0]     physical_address;
        logic [VA_W-1:0]     page_base_virtual;
        logic                mapped;
        logic                allow_execute;
        logic                allow_read;
        logic                allow_write;
    } t_out_item;

    // base table write request from the walk stage
    typedef struct packed {
        logic                en;
        logic [CTX_W-1:0]    context_id;
        logic [FRAME_W-1:0]  frame;
    } t_base_wr;

endpackage

FILE: hdl/twlk_ifs.sv
// request and response channel interfaces of the page table walker

interface twlk_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [twlk_pkg::CTX_W-1:0]    context_id;
    logic [twlk_pkg::FRAME_W-1:0]  base_frame;
    logic [twlk_pkg::VA_W-1:0]     virtual_address;
    logic [twlk_pkg::DATA_W-1:0]   read_data;

    modport source (
        output valid, operation, context_id, base_frame, virtual_address, read_data,
        input  ready
    );
    modport sink (
        input  valid, operation, context_id, base_frame, virtual_address, read_data,
        output ready
    );
endinterface

interface twlk_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    result_kind;
    logic [twlk_pkg::FRAME_W-1:0]  readback_frame;
    logic [twlk_pkg::VA_W-1:0]     memory_address;
    logic [twlk_pkg::VA_W-1:0]     physical_address;
    logic [twlk_pkg::VA_W-1:0]     page_base_virtual;
    logic                          mapped;
    logic                          allow_execute;
    logic                          allow_read;
    logic                          allow_write;

    modport source (
        output valid, result_kind, readback_frame, memory_address, physical_address,
               page_base_virtual, mapped, allow_execute, allow_read, allow_write,
        input  ready
    );
    modport sink (
        input  valid, result_kind, readback_frame, memory_address, physical_address,
               page_base_virtual, mapped, allow_execute, allow_read, allow_write,
        output ready
    );
endinterface

FILE: hdl/twlk_ctx_table.sv
// per-context page table base frame registers
module twlk_ctx_table #(
    parameter int CONTEXT_COUNT = twlk_pkg::CONTEXT_COUNT_DFLT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  twlk_pkg::t_base_wr            i_wr,
    input  logic [twlk_pkg::CTX_W-1:0]    i_rd_ctx,
    output logic [twlk_pkg::FRAME_W-1:0]  o_rd_frame
);

    localparam int IDX_W = (CONTEXT_COUNT > 1) ? $clog2(CONTEXT_COUNT) : 1;

    logic [twlk_pkg::FRAME_W-1:0] r_base [CONTEXT_COUNT];
    logic                         wr_in_range;
    logic                         rd_in_range;

    assign wr_in_range = ({1'b0, i_wr.context_id} < (twlk_pkg::CTX_W+1)'(CONTEXT_COUNT));
    assign rd_in_range = ({1'b0, i_rd_ctx} < (twlk_pkg::CTX_W+1)'(CONTEXT_COUNT));

    // base frames, zero after reset means no translation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CONTEXT_COUNT; i++) begin
                r_base[i] <= '0;
            end
        end else if (i_wr.en && wr_in_range) begin
            r_base[i_wr.context_id[IDX_W-1:0]] <= i_wr.frame;
        end
    end

    // contexts beyond the table read as zero
    assign o_rd_frame = rd_in_range ? r_base[i_rd_ctx[IDX_W-1:0]] : '0;

endmodule

FILE: hdl/twlk_walk.sv
// walk sequencer: decodes one item and forms its result
module twlk_walk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  twlk_pkg::t_in_item            i_item,
    input  logic [twlk_pkg::FRAME_W-1:0]  i_base,
    output twlk_pkg::t_base_wr            o_base_wr,
    output logic                          o_res_valid,
    output twlk_pkg::t_out_item           o_res
);

    localparam int VA_W = twlk_pkg::VA_W;

    twlk_pkg::t_phase         r_phase;
    twlk_pkg::t_phase         n_phase;
    logic [VA_W-1:0]          r_saved_va;
    logic [VA_W-1:0]          n_saved_va;
    logic                     base_zero;
    logic [VA_W-1:0]          dir_addr;
    logic [VA_W-1:0]          tbl_addr;

    assign base_zero = (i_base == '0);

    // directory entry address: base page plus directory index times 8
    assign dir_addr = {i_base, {twlk_pkg::PAGE_W{1'b0}}}
                    + VA_W'({i_item.virtual_address[VA_W-1:23], 3'b000});

    // table entry address: directory entry with low byte cleared plus table index times 8
    assign tbl_addr = {i_item.read_data[VA_W-1:8], 8'h00}
                    + VA_W'({r_saved_va[22:12], 3'b000});

    // base table write
    always_comb begin
        o_base_wr.en         = i_fire && (i_item.operation == twlk_pkg::OP_WRITE_BASE);
        o_base_wr.context_id = i_item.context_id;
        o_base_wr.frame      = i_item.base_frame;
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_saved_va = r_saved_va;
        if (i_fire) begin
            unique case (r_phase)
                twlk_pkg::PH_IDLE: begin
                    if (i_item.operation == twlk_pkg::OP_TRANSLATE && !base_zero) begin
                        n_phase    = twlk_pkg::PH_DIR;
                        n_saved_va = i_item.virtual_address;
                    end
                end
                twlk_pkg::PH_DIR: begin
                    if (i_item.operation == twlk_pkg::OP_READ_DATA) begin
                        n_phase = twlk_pkg::PH_TABLE;
                    end
                end
                twlk_pkg::PH_TABLE: begin
                    if (i_item.operation == twlk_pkg::OP_READ_DATA) begin
                        n_phase = twlk_pkg::PH_IDLE;
                    end
                end
                default: n_phase = twlk_pkg::PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= twlk_pkg::PH_IDLE;
            r_saved_va <= '0;
        end else begin
            r_phase    <= n_phase;
            r_saved_va <= n_saved_va;
        end
    end

    // result of the current item
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (i_item.operation)
            twlk_pkg::OP_WRITE_BASE: begin
                o_res_valid = 1'b0;
            end
            twlk_pkg::OP_READ_BASE: begin
                o_res_valid          = 1'b1;
                o_res.result_kind    = twlk_pkg::KIND_READBACK;
                o_res.readback_frame = i_base;
            end
            twlk_pkg::OP_TRANSLATE: begin
                // ignored while a walk is in progress
                if (r_phase == twlk_pkg::PH_IDLE) begin
                    o_res_valid = 1'b1;
                    if (base_zero) begin
                        o_res.result_kind = twlk_pkg::KIND_XLATE;
                    end else begin
                        o_res.result_kind    = twlk_pkg::KIND_MEM_REQ;
                        o_res.memory_address = dir_addr;
                    end
                end
            end
            twlk_pkg::OP_READ_DATA: begin
                if (r_phase == twlk_pkg::PH_DIR) begin
                    o_res_valid          = 1'b1;
                    o_res.result_kind    = twlk_pkg::KIND_MEM_REQ;
                    o_res.memory_address = tbl_addr;
                end else if (r_phase == twlk_pkg::PH_TABLE) begin
                    o_res_valid             = 1'b1;
                    o_res.result_kind       = twlk_pkg::KIND_XLATE;
                    o_res.physical_address  = {i_item.read_data[VA_W-1:twlk_pkg::PAGE_W],
                                               r_saved_va[twlk_pkg::PAGE_W-1:0]};
                    o_res.page_base_virtual = {r_saved_va[VA_W-1:twlk_pkg::PAGE_W],
                                               {twlk_pkg::PAGE_W{1'b0}}};
                    o_res.mapped            = 1'b1;
                    o_res.allow_execute     = i_item.read_data[4];
                    o_res.allow_read        = i_item.read_data[5];
                    o_res.allow_write       = i_item.read_data[6];
                end
            end
            default: o_res_valid = 1'b0;
        endcase
    end

    // a translate on a mapped context starts the directory fetch
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_phase == twlk_pkg::PH_IDLE && i_item.operation == twlk_pkg::OP_TRANSLATE
        && !base_zero |=> r_phase == twlk_pkg::PH_DIR)
        else $error("walk did not enter directory phase");

    // memory requests come only from a translate or a directory entry
    a_req_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.result_kind == twlk_pkg::KIND_MEM_REQ |->
        i_item.operation == twlk_pkg::OP_TRANSLATE
        || (i_item.operation == twlk_pkg::OP_READ_DATA && r_phase == twlk_pkg::PH_DIR))
        else $error("memory request from unexpected item");

    // a mapped translation ends a walk
    a_mapped_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res_valid && o_res.mapped |=> r_phase == twlk_pkg::PH_IDLE)
        else $error("walk not idle after mapped result");

endmodule

FILE: hdl/two_level_page_table_walker.sv
// Two-level page table walker, top level.
// Items enter on the i_req channel (valid/ready): write context base,
// read context base, translate request, or memory read data. Results leave
// on the o_rsp channel: base readback, memory read request, or translation.
// A translate on a context with a nonzero base asks for the directory entry;
// the returned directory entry makes the walker ask for the table entry;
// the returned table entry gives the physical address and permissions.
// Base writes and stray read data give no result; a translate during a walk
// is dropped. Each item passes an input register and a result register,
// with the single decode stage between the registers, and one item is
// taken every cycle while o_rsp does not stall.
// Memory latency lies in the caller's loop, outside the block.
// When o_rsp stalls, the result register holds and the input register keeps
// one more item, after which i_req.ready drops.
// Reset clears every context base to zero (unmapped) and idles the walk.
module two_level_page_table_walker #(
    parameter int CONTEXT_COUNT = twlk_pkg::CONTEXT_COUNT_DFLT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    twlk_req_if.sink    i_req,
    twlk_rsp_if.source  o_rsp
);

    logic                         r_in_valid;
    twlk_pkg::t_in_item           r_in_item;
    logic                         r_out_valid;
    twlk_pkg::t_out_item          r_out_item;
    logic                         advance;
    logic                         fire;
    logic [twlk_pkg::FRAME_W-1:0] base;
    twlk_pkg::t_base_wr           base_wr;
    logic                         res_valid;
    twlk_pkg::t_out_item          res;

    // pipeline control
    assign advance     = !r_out_valid || o_rsp.ready;
    assign fire        = r_in_valid && advance;
    assign i_req.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_item.operation       <= twlk_pkg::t_op'(i_req.operation);
            r_in_item.context_id      <= i_req.context_id;
            r_in_item.base_frame      <= i_req.base_frame;
            r_in_item.virtual_address <= i_req.virtual_address;
            r_in_item.read_data       <= i_req.read_data;
        end
    end

    twlk_ctx_table #(
        .CONTEXT_COUNT (CONTEXT_COUNT)
    ) u_ctx_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (base_wr),
        .i_rd_ctx   (r_in_item.context_id),
        .o_rd_frame (base)
    );

    twlk_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in_item),
        .i_base      (base),
        .o_base_wr   (base_wr),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= res;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.result_kind       = r_out_item.result_kind;
    assign o_rsp.readback_frame    = r_out_item.readback_frame;
    assign o_rsp.memory_address    = r_out_item.memory_address;
    assign o_rsp.physical_address  = r_out_item.physical_address;
    assign o_rsp.page_base_virtual = r_out_item.page_base_virtual;
    assign o_rsp.mapped            = r_out_item.mapped;
    assign o_rsp.allow_execute     = r_out_item.allow_execute;
    assign o_rsp.allow_read        = r_out_item.allow_read;
    assign o_rsp.allow_write       = r_out_item.allow_write;

    // a held item stays put while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_item))
        else $error("input register lost an item during stall");

    // a processed item with a result shows up on the output next cycle
    a_res_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res_valid |=> r_out_valid && o_rsp.result_kind == $past(res.result_kind))
        else $error("result not registered");

endmodule

FILE: bench/twlk_walk_checker.sv
`timescale 1ns / 1ps
// walker result predictor and comparator that watches the request and result channels
module twlk_walk_checker #(
    parameter int CONTEXT_COUNT = twlk_pkg::CONTEXT_COUNT_DFLT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    twlk_req_if  i_req,
    twlk_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    // predicted walker state
    logic [twlk_pkg::FRAME_W-1:0] base_table [16];
    twlk_pkg::t_phase             walk_state;
    logic [twlk_pkg::VA_W-1:0]    saved_va;

    // results still owed by the block, oldest first
    twlk_pkg::t_out_item          walker_results [$];

    // advance the predicted walker by one accepted item
    task automatic step_walker(input twlk_pkg::t_in_item it, output bit produces,
                               output twlk_pkg::t_out_item res);
        logic [twlk_pkg::FRAME_W-1:0] base;
        logic                         ctx_ok;
        produces = 1'b0;
        res      = '0;
        ctx_ok   = int'(it.context_id) < CONTEXT_COUNT;
        base     = ctx_ok ? base_table[it.context_id] : '0;
        case (it.operation)
            twlk_pkg::OP_WRITE_BASE: begin
                if (ctx_ok)
                    base_table[it.context_id] = it.base_frame;
            end
            twlk_pkg::OP_READ_BASE: begin
                produces           = 1'b1;
                res.result_kind    = twlk_pkg::KIND_READBACK;
                res.readback_frame = base;
            end
            twlk_pkg::OP_TRANSLATE: begin
                // dropped while a walk is open
                if (walk_state == twlk_pkg::PH_IDLE) begin
                    produces = 1'b1;
                    if (base == '0) begin
                        res.result_kind = twlk_pkg::KIND_XLATE;
                    end else begin
                        saved_va           = it.virtual_address;
                        walk_state         = twlk_pkg::PH_DIR;
                        res.result_kind    = twlk_pkg::KIND_MEM_REQ;
                        res.memory_address = {base, 12'h000}
                                           + {20'd0, it.virtual_address[39:23], 3'b000};
                    end
                end
            end
            default: begin
                // memory data: directory entry, then table entry, else stray
                if (walk_state == twlk_pkg::PH_DIR) begin
                    produces           = 1'b1;
                    walk_state         = twlk_pkg::PH_TABLE;
                    res.result_kind    = twlk_pkg::KIND_MEM_REQ;
                    res.memory_address = {it.read_data[39:8], 8'h00}
                                       + {26'd0, saved_va[22:12], 3'b000};
                end else if (walk_state == twlk_pkg::PH_TABLE) begin
                    produces              = 1'b1;
                    walk_state            = twlk_pkg::PH_IDLE;
                    res.result_kind       = twlk_pkg::KIND_XLATE;
                    res.physical_address  = {it.read_data[39:12], saved_va[11:0]};
                    res.page_base_virtual = {saved_va[39:12], 12'h000};
                    res.mapped            = 1'b1;
                    res.allow_execute     = it.read_data[4];
                    res.allow_read        = it.read_data[5];
                    res.allow_write       = it.read_data[6];
                end
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            o_fail_count++;
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        twlk_pkg::t_in_item  item;
        twlk_pkg::t_out_item want;
        twlk_pkg::t_out_item got;
        bit                  produces;
        if (!i_rst_n) begin
            foreach (base_table[i])
                base_table[i] = '0;
            walk_state = twlk_pkg::PH_IDLE;
            saved_va   = '0;
            walker_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                item.operation       = twlk_pkg::t_op'(i_req.operation);
                item.context_id      = i_req.context_id;
                item.base_frame      = i_req.base_frame;
                item.virtual_address = i_req.virtual_address;
                item.read_data       = i_req.read_data;
                step_walker(item, produces, want);
                if (produces)
                    walker_results.push_back(want);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.result_kind       = twlk_pkg::t_kind'(i_rsp.result_kind);
                got.readback_frame    = i_rsp.readback_frame;
                got.memory_address    = i_rsp.memory_address;
                got.physical_address  = i_rsp.physical_address;
                got.page_base_virtual = i_rsp.page_base_virtual;
                got.mapped            = i_rsp.mapped;
                got.allow_execute     = i_rsp.allow_execute;
                got.allow_read        = i_rsp.allow_read;
                got.allow_write       = i_rsp.allow_write;
                if (walker_results.size() == 0) begin
                    $error("result_kind: expected no item, actual %0h", i_rsp.result_kind);
                    o_fail_count++;
                end else begin
                    want = walker_results.pop_front();
                    check_field("result_kind", 64'(want.result_kind),
                                64'(i_rsp.result_kind));
                    check_field("readback_frame", 64'(want.readback_frame),
                                64'(got.readback_frame));
                    check_field("memory_address", 64'(want.memory_address),
                                64'(got.memory_address));
                    check_field("physical_address", 64'(want.physical_address),
                                64'(got.physical_address));
                    check_field("page_base_virtual", 64'(want.page_base_virtual),
                                64'(got.page_base_virtual));
                    check_field("mapped", 64'(want.mapped), 64'(got.mapped));
                    check_field("allow_execute", 64'(want.allow_execute),
                                64'(got.allow_execute));
                    check_field("allow_read", 64'(want.allow_read), 64'(got.allow_read));
                    check_field("allow_write", 64'(want.allow_write),
                                64'(got.allow_write));
                end
            end
        end
        o_pending = walker_results.size();
    end

endmodule

FILE: bench/two_level_page_table_walker_tb.sv
`timescale 1ns / 1ps
// top of the page table walker bench: clock, reset, item stimulus, stalls and verdict
module two_level_page_table_walker_tb;

    localparam int ITEM_TARGET  = 1650;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 10;

    logic i_clk;
    logic i_rst_n;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    int   sent_count   = 0;
    int   quiet_cycles = 0;
    int   fail_count;
    int   pending;

    twlk_req_if walk_req ();
    twlk_rsp_if walk_rsp ();

    two_level_page_table_walker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (walk_req),
        .o_rsp   (walk_rsp)
    );

    twlk_walk_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (walk_req),
        .i_rsp        (walk_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side back-pressure
    initial begin
        walk_rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            walk_rsp.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((walk_req.valid && walk_req.ready) || (walk_rsp.valid && walk_rsp.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // random word, with all zeros and all ones now and then
    function automatic logic [63:0] rand_word();
        logic [63:0] v;
        int          pick;
        pick = $urandom_range(19);
        v    = {$urandom, $urandom};
        if (pick == 0)
            v = '0;
        else if (pick == 1)
            v = '1;
        return v;
    endfunction

    function automatic twlk_pkg::t_in_item random_item(input twlk_pkg::t_op op);
        twlk_pkg::t_in_item it;
        logic [63:0]        w;
        it.operation       = op;
        it.context_id      = (twlk_pkg::CTX_W)'($urandom_range(15));
        w                  = rand_word();
        it.base_frame      = w[twlk_pkg::FRAME_W-1:0];
        w                  = rand_word();
        it.virtual_address = w[twlk_pkg::VA_W-1:0];
        it.read_data       = rand_word();
        return it;
    endfunction

    // present one item at the falling edge and hold it until accepted
    task automatic send_item(input twlk_pkg::t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            walk_req.valid = 1'b0;
            @(negedge i_clk);
        end
        walk_req.valid           = 1'b1;
        walk_req.operation       = it.operation;
        walk_req.context_id      = it.context_id;
        walk_req.base_frame      = it.base_frame;
        walk_req.virtual_address = it.virtual_address;
        walk_req.read_data       = it.read_data;
        @(posedge i_clk);
        while (!walk_req.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic send_fields(input twlk_pkg::t_op op,
                               input logic [twlk_pkg::CTX_W-1:0] ctx,
                               input logic [twlk_pkg::FRAME_W-1:0] frame,
                               input logic [twlk_pkg::VA_W-1:0] va,
                               input logic [twlk_pkg::DATA_W-1:0] data);
        twlk_pkg::t_in_item it;
        it.operation       = op;
        it.context_id      = ctx;
        it.base_frame      = frame;
        it.virtual_address = va;
        it.read_data       = data;
        send_item(it);
    endtask

    // occasional base access or extra translate in the middle of a walk
    task automatic walk_interject();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            send_item(random_item(twlk_pkg::OP_WRITE_BASE));
        else if (pick < 10)
            send_item(random_item(twlk_pkg::OP_READ_BASE));
        else if (pick < 15)
            send_item(random_item(twlk_pkg::OP_TRANSLATE));
    endtask

    // one random burst: mostly complete walks, some noise and broken walks
    task automatic random_burst();
        twlk_pkg::t_in_item it;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            it = random_item(twlk_pkg::OP_WRITE_BASE);
            if ($urandom_range(19) == 0)
                it.base_frame = '0;
            send_item(it);
        end else if (pick < 22) begin
            send_item(random_item(twlk_pkg::OP_READ_BASE));
        end else if (pick < 26) begin
            send_item(random_item(twlk_pkg::OP_READ_DATA));
        end else if (pick < 29) begin
            send_item(random_item(twlk_pkg::OP_TRANSLATE));
        end else begin
            send_item(random_item(twlk_pkg::OP_TRANSLATE));
            walk_interject();
            if ($urandom_range(19) != 0)
                send_item(random_item(twlk_pkg::OP_READ_DATA));
            walk_interject();
            if ($urandom_range(19) != 0)
                send_item(random_item(twlk_pkg::OP_READ_DATA));
        end
    endtask

    // stimulus and verdict
    initial begin
        twlk_pkg::t_in_item it;
        i_rst_n                  = 1'b0;
        walk_req.valid           = 1'b0;
        walk_req.operation       = twlk_pkg::OP_WRITE_BASE;
        walk_req.context_id      = '0;
        walk_req.base_frame      = '0;
        walk_req.virtual_address = '0;
        walk_req.read_data       = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // bases are zero after reset: readback, unmapped translate, stray data
        send_fields(twlk_pkg::OP_READ_BASE, 4'd0, '0, '0, '0);
        send_fields(twlk_pkg::OP_TRANSLATE, 4'd0, '1, 40'hAB_CDEF_0123, '1);
        send_fields(twlk_pkg::OP_READ_DATA, 4'd15, '1, '1, '1);
        // extreme bases and readback
        send_fields(twlk_pkg::OP_WRITE_BASE, 4'd0, '1, '0, '0);
        send_fields(twlk_pkg::OP_WRITE_BASE, 4'd15, 28'd1, '1, '1);
        send_fields(twlk_pkg::OP_READ_BASE, 4'd0, '0, '0, '0);
        send_fields(twlk_pkg::OP_READ_BASE, 4'd15, '0, '0, '0);
        send_fields(twlk_pkg::OP_READ_BASE, 4'd7, '1, '1, '1);
        // walk with all-ones address: both fetch addresses wrap at 40 bits
        send_fields(twlk_pkg::OP_TRANSLATE, 4'd0, '0, '1, '0);
        // translate and base accesses while the walk is open
        send_fields(twlk_pkg::OP_TRANSLATE, 4'd15, '0, 40'h12_3456_7000, '0);
        send_fields(twlk_pkg::OP_WRITE_BASE, 4'd7, 28'h5A5_A5A5, '0, '0);
        send_fields(twlk_pkg::OP_READ_BASE, 4'd7, '0, '0, '0);
        send_fields(twlk_pkg::OP_READ_DATA, 4'd0, '0, '0, '1);
        send_fields(twlk_pkg::OP_READ_DATA, 4'd0, '0, '0, 64'hFFFF_FFFF_FFFF_F070);
        // walk with zero address and zero entries
        send_fields(twlk_pkg::OP_TRANSLATE, 4'd15, '0, '0, '0);
        send_fields(twlk_pkg::OP_READ_DATA, 4'd15, '0, '0, '0);
        send_fields(twlk_pkg::OP_READ_DATA, 4'd15, '0, '0, '0);
        // walk with single permission bits
        send_fields(twlk_pkg::OP_TRANSLATE, 4'd7, '0, 40'h12_3456_789A, '0);
        send_fields(twlk_pkg::OP_READ_DATA, 4'd7, '0, '0, 64'h0000_00AB_CDEF_0010);
        send_fields(twlk_pkg::OP_READ_DATA, 4'd7, '0, '0, 64'hA5A5_5A5A_A5A5_5A40);
        // base cleared again gives unmapped, then stray data while idle
        send_fields(twlk_pkg::OP_WRITE_BASE, 4'd15, '0, '0, '0);
        send_fields(twlk_pkg::OP_TRANSLATE, 4'd15, '0, '1, '1);
        send_fields(twlk_pkg::OP_READ_DATA, 4'd0, '0, '0, '0);

        // give every context a nonzero base before the random part
        for (int c = 0; c < 16; c++) begin
            it            = random_item(twlk_pkg::OP_WRITE_BASE);
            it.context_id = (twlk_pkg::CTX_W)'(c);
            if (it.base_frame == '0)
                it.base_frame = 28'd1;
            send_item(it);
        end

        // idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 51;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 51;
                end
                default: begin
                    idle_pct  = 27;
                    stall_pct = 27;
                end
            endcase
            while (sent_count < ITEM_TARGET * (ph + 1) / 4)
                random_burst();
        end

        // drain the remaining results
        walk_req.valid = 1'b0;
        stall_pct      = 0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
